// ----- sv/wts_pkg.sv -----
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and fixed constants of the tile edge-color pixel shader.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

   localparam int COORD_W  = 17;
   localparam int COLOR_W  = 17;
   localparam int STRIDE_W = 13;
   localparam int INDEX_W  = 19;
   localparam int LANES    = 4;

   localparam logic [COLOR_W-1:0] Q16_ONE = 17'd65536;

   // edge midpoints in order: right, v = 0, left, v = 1 (element 0 is right)
   localparam logic [LANES-1:0][COORD_W-1:0] MID_U =
      {17'd32768, 17'd0, 17'd32768, 17'd65536};
   localparam logic [LANES-1:0][COORD_W-1:0] MID_V =
      {17'd65536, 17'd32768, 17'd0, 17'd32768};

   localparam logic [7:0] ALPHA_BYTE = 8'hFF;

   typedef struct packed {
      logic [6:0] pixel_x;
      logic [6:0] pixel_y;
      logic [3:0] edge_code;
   } wts_req_type;

   typedef struct packed {
      logic [31:0]        pixel_word;
      logic [INDEX_W-1:0] pixel_index;
   } wts_rsp_type;

   typedef struct packed {
      logic [3:0]         code;
      logic [INDEX_W-1:0] index;
   } wts_side_type;

endpackage

`default_nettype wire

// ----- sv/wts_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// wts_sqrt_pipe
// Five-stage integer square root of a 30-bit value, three result bits per
// stage, with a pass-through flag for values out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_sqrt_pipe
   import wts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic        big_in,
   input  wire logic [29:0] value_in,
   output logic             big_out,
   output logic [14:0]      root_out
);

   localparam int STAGES = 5;
   localparam int STEPS  = 3;

   logic [30:0] rem_ff [STAGES];
   logic [30:0] res_ff [STAGES];
   logic        big_ff [STAGES];

   function automatic logic [61:0] sqrt_steps(logic [30:0] rem, logic [30:0] res, int first);
      logic [30:0] r;
      logic [30:0] q;
      logic [30:0] b;
      r = rem;
      q = res;
      for (int j = 0; j < STEPS; j++) begin
         b = 31'(1) << (28 - 2 * (first + j));
         if (r >= q + b) begin
            r = r - (q + b);
            q = (q >> 1) + b;
         end else begin
            q = q >> 1;
         end
      end
      return {r, q};
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         {rem_ff[0], res_ff[0]} <= sqrt_steps({1'b0, value_in}, '0, 0);
         big_ff[0] <= big_in;
         for (int s = 1; s < STAGES; s++) begin
            {rem_ff[s], res_ff[s]} <= sqrt_steps(rem_ff[s-1], res_ff[s-1], s * STEPS);
            big_ff[s] <= big_ff[s-1];
         end
      end
   end

   assign big_out  = big_ff[STAGES-1];
   assign root_out = res_ff[STAGES-1][14:0];

endmodule

`default_nettype wire

// ----- sv/wang_tile_pixel_shader_core.sv -----
// ----------------------------------------------------------------------------
// wang_tile_pixel_shader_core
// Edge-color shader for one tile pixel per cycle, with gamma and packing.
//
// A request carries pixel_x, pixel_y and edge_code on req_data; it is taken
// when req_valid and req_ready are high. Each request yields one response
// on rsp_data (packed ABGR word and destination index) under rsp_valid /
// rsp_ready. The csr write channel loads row_stride; csr_ready is always
// high and the write takes effect for requests taken after it.
// The pipeline has 12 register stages: one for the coordinate table and
// squared distances, five for the square-root lanes, four for the chained
// lerps, one for the gamma index and one for the registered gamma table
// read. Throughput is one pixel per cycle while the receiver does not
// stall.
// When the receiver stalls, the whole pipeline holds and req_ready drops
// until the output register is taken. Reset clears all stage valid bits
// and sets row_stride to 512.
// ----------------------------------------------------------------------------
`default_nettype none

module wang_tile_pixel_shader_core
   import wts_pkg::*;
#(
   parameter int TILE_WIDTH        = 128,
   parameter int TILE_HEIGHT       = 128,
   parameter int GAMMA_TABLE_DEPTH = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire wts_req_type         req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output wts_rsp_type              rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [STRIDE_W-1:0] csr_data
);

   localparam int NSTAGE = 12;
   localparam int IDXW   = $clog2(GAMMA_TABLE_DEPTH);
   localparam int PW     = COLOR_W + IDXW + 1;
   localparam logic [PW-1:0] DM1 = PW'(GAMMA_TABLE_DEPTH - 1);

   function automatic logic [128*COORD_W-1:0] build_u();
      logic [128*COORD_W-1:0] tab;
      logic [31:0] q;
      for (int p = 0; p < 128; p++) begin
         q = (32'(p) << 16) / TILE_WIDTH;
         tab[p*COORD_W +: COORD_W] = (q > 32'h1FFFF) ? 17'h1FFFF : q[16:0];
      end
      return tab;
   endfunction

   function automatic logic [128*COORD_W-1:0] build_v();
      logic [128*COORD_W-1:0] tab;
      logic [31:0] q;
      for (int p = 0; p < 128; p++) begin
         q = (32'(p) << 16) / TILE_HEIGHT;
         tab[p*COORD_W +: COORD_W] = (q > 32'h1FFFF) ? 17'h1FFFF : q[16:0];
      end
      return tab;
   endfunction

   function automatic logic [7:0] gamma_byte(int k);
      logic [255:0] den5;
      logic [255:0] rhs;
      logic [255:0] lhs;
      logic [255:0] wide;
      int lo;
      int hi;
      int mid;
      den5 = 256'(1);
      rhs  = 256'(1);
      for (int i = 0; i < 5; i++) begin
         den5 = den5 * 256'(GAMMA_TABLE_DEPTH - 1);
         rhs  = rhs * 256'(k);
      end
      rhs = rhs << 176;
      lo = 0;
      hi = 65536;
      for (int it = 0; it < 18; it++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 256'(1);
            for (int i = 0; i < 11; i++) lhs = lhs * 256'(mid);
            lhs = lhs * den5;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
      end
      wide = (256'(lo) * 256'(255)) >> 16;
      return wide[7:0];
   endfunction

   function automatic logic [GAMMA_TABLE_DEPTH*8-1:0] build_gamma();
      logic [GAMMA_TABLE_DEPTH*8-1:0] tab;
      for (int k = 0; k < GAMMA_TABLE_DEPTH; k++) tab[k*8 +: 8] = gamma_byte(k);
      return tab;
   endfunction

   localparam logic [128*COORD_W-1:0]         U_TAB     = build_u();
   localparam logic [128*COORD_W-1:0]         V_TAB     = build_v();
   localparam logic [GAMMA_TABLE_DEPTH*8-1:0] GAMMA_ROM = build_gamma();

   logic                stride_ff;
   logic [STRIDE_W-1:0] row_stride_ff;
   logic                en;
   logic                v_ff [NSTAGE];
   wts_side_type        side_ff [NSTAGE-1];
   wts_side_type        side_in;

   logic [COORD_W-1:0]  u_val;
   logic [COORD_W-1:0]  v_val;
   logic signed [18:0]  du [LANES];
   logic signed [18:0]  dv [LANES];
   logic [35:0]         d2_in [LANES];
   logic [35:0]         d2_ff [LANES];

   logic                big [LANES];
   logic [14:0]         root [LANES];
   logic [LANES-1:0][COLOR_W-1:0] tq;

   logic [LANES-1:0][COLOR_W-1:0] t_ff [LANES];
   logic [LANES-1:0][COLOR_W-1:0] t_in [LANES];
   logic [COLOR_W-1:0]  r_ff [LANES];
   logic [COLOR_W-1:0]  g_ff [LANES];
   logic [COLOR_W-1:0]  r_in [LANES];
   logic [COLOR_W-1:0]  g_in [LANES];
   logic [COLOR_W-1:0]  t_sel [LANES];
   logic [COLOR_W-1:0]  keep [LANES];
   logic [COLOR_W-1:0]  r_prev [LANES];
   logic [COLOR_W-1:0]  g_prev [LANES];
   logic [33:0]         r_mul [LANES];
   logic [33:0]         g_mul [LANES];
   logic                code_bit [LANES];

   logic [PW-1:0]       pr;
   logic [PW-1:0]       pg;
   logic [PW-1:0]       sr;
   logic [PW-1:0]       sg;
   logic [IDXW-1:0]     gi_r_ff;
   logic [IDXW-1:0]     gi_g_ff;
   logic [7:0]          byte_r_ff;
   logic [7:0]          byte_g_ff;
   logic [INDEX_W-1:0]  out_index_ff;

   assign csr_ready = 1'b1;
   assign en        = !v_ff[NSTAGE-1] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff <= 13'd512;
         stride_ff     <= 1'b0;
      end else begin
         stride_ff <= 1'b1;
         if (csr_valid && csr_ready) row_stride_ff <= csr_data;
      end
   end

   // stage 0: coordinates and squared distances
   always_comb begin
      u_val = U_TAB[req_data.pixel_x * COORD_W +: COORD_W];
      v_val = V_TAB[req_data.pixel_y * COORD_W +: COORD_W];
      for (int i = 0; i < LANES; i++) begin
         du[i]    = $signed({2'b00, MID_U[i]}) - $signed({2'b00, u_val});
         dv[i]    = $signed({2'b00, MID_V[i]}) - $signed({2'b00, v_val});
         d2_in[i] = 36'(36'(du[i]) * 36'(du[i])) + 36'(36'(dv[i]) * 36'(dv[i]));
      end
      side_in.code  = req_data.edge_code;
      side_in.index = INDEX_W'(20'(req_data.pixel_y) * 20'(row_stride_ff)
                               + 20'(req_data.pixel_x));
   end

   genvar gl;
   generate
      for (gl = 0; gl < LANES; gl++) begin : g_lane
         wts_sqrt_pipe u_sqrt (
            .clock    (clock),
            .enable   (en),
            .big_in   (|d2_ff[gl][35:30]),
            .value_in (d2_ff[gl][29:0]),
            .big_out  (big[gl]),
            .root_out (root[gl])
         );
      end
   endgenerate

   // lerp chain: red and green only, blue always follows green
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         tq[i] = big[i] ? '0 : Q16_ONE - 17'({root[i], 1'b0});
      end
      t_in[0]   = tq;
      r_prev[0] = '0;
      g_prev[0] = '0;
      for (int j = 1; j < LANES; j++) begin
         t_in[j]   = t_ff[j-1];
         r_prev[j] = r_ff[j-1];
         g_prev[j] = g_ff[j-1];
      end
      for (int j = 0; j < LANES; j++) begin
         t_sel[j]    = t_in[j][j];
         keep[j]     = Q16_ONE - t_sel[j];
         code_bit[j] = side_ff[5+j].code[j];
         r_mul[j]    = 34'(r_prev[j]) * 34'(keep[j]);
         g_mul[j]    = 34'(g_prev[j]) * 34'(keep[j]);
         r_in[j]     = r_mul[j][32:16] + (code_bit[j] ? '0 : t_sel[j]);
         g_in[j]     = g_mul[j][32:16] + (code_bit[j] ? t_sel[j] : '0);
      end
      pr = PW'(r_ff[LANES-1]) * DM1 + PW'(32768);
      pg = PW'(g_ff[LANES-1]) * DM1 + PW'(32768);
      sr = pr >> 16;
      sg = pg >> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTAGE; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int s = 1; s < NSTAGE; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < NSTAGE - 1; s++) side_ff[s] <= side_ff[s-1];
         for (int i = 0; i < LANES; i++) begin
            d2_ff[i] <= d2_in[i];
            t_ff[i]  <= t_in[i];
            r_ff[i]  <= r_in[i];
            g_ff[i]  <= g_in[i];
         end
         gi_r_ff      <= (sr > DM1) ? IDXW'(DM1) : IDXW'(sr);
         gi_g_ff      <= (sg > DM1) ? IDXW'(DM1) : IDXW'(sg);
         byte_r_ff    <= GAMMA_ROM[{gi_r_ff, 3'b000} +: 8];
         byte_g_ff    <= GAMMA_ROM[{gi_g_ff, 3'b000} +: 8];
         out_index_ff <= side_ff[NSTAGE-2].index;
      end
   end

   assign rsp_valid              = v_ff[NSTAGE-1];
   assign rsp_data.pixel_word    = {ALPHA_BYTE, byte_g_ff, byte_g_ff, byte_r_ff};
   assign rsp_data.pixel_index   = out_index_ff;

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pixel_word[31:24] == ALPHA_BYTE)
      else $error("alpha byte not FF");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NSTAGE-1] && !rsp_ready) |=> (v_ff[NSTAGE-2] == $past(v_ff[NSTAGE-2]))
         && (v_ff[0] == $past(v_ff[0])))
      else $error("pipeline advanced during stall");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[9] |-> (r_ff[LANES-1] <= Q16_ONE) && (g_ff[LANES-1] <= Q16_ONE))
      else $error("lerp result above one");

   a_stride_reset: assert property (@(posedge clock)
      (stride_ff && $past(reset)) |-> row_stride_ff == 13'd512)
      else $error("row stride not reset");

endmodule

`default_nettype wire

// ----- sim/wang_tile_pixel_shader_core_tb.sv -----
// ----------------------------------------------------------------------------
// wang_tile_pixel_shader_core_tb
// Streams tile pixels through the edge-color shader and checks every packed
// color word and destination index against an in-bench fixed-point shader
// model, across several row strides, random idling and output backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wang_tile_pixel_shader_core_tb;
   import wts_pkg::*;

   localparam int TILE_W  = 128;
   localparam int TILE_H  = 128;
   localparam int GAMMA_D = 1024;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   wts_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   wts_rsp_type       rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [STRIDE_W-1:0] csr_data;

   logic [16:0]       gamma_lut [GAMMA_D];
   logic [STRIDE_W-1:0] cur_stride;
   wts_rsp_type       pending_pixels [$];
   int                errors;
   int                stall_left;
   bit                req_idle_on;
   bit                rsp_idle_on;

   wang_tile_pixel_shader_core #(
      .TILE_WIDTH(TILE_W), .TILE_HEIGHT(TILE_H), .GAMMA_TABLE_DEPTH(GAMMA_D)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void build_gamma();
      logic [255:0] rhs;
      logic [255:0] lhs;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      for (int k = 0; k < GAMMA_D; k++) begin
         rhs = 256'd1;
         for (int i = 0; i < 5; i++) rhs = rhs * 256'(k);
         rhs = rhs << 176;
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 256'd1;
            for (int i = 0; i < 11; i++) lhs = lhs * 256'(mid);
            for (int i = 0; i < 5; i++) lhs = lhs * 256'(GAMMA_D - 1);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         gamma_lut[k] = lo[16:0];
      end
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint gamma_byte(longint c);
      longint idx;
      idx = (c * (GAMMA_D - 1) + 32768) >> 16;
      if (idx >= GAMMA_D) idx = GAMMA_D - 1;
      return ((longint'(gamma_lut[idx]) * 255) >> 16) & 255;
   endfunction

   function automatic wts_rsp_type shade_pixel(wts_req_type p, logic [STRIDE_W-1:0] stride);
      wts_rsp_type o;
      longint u, v, du, dv, twice, t, keep, tr, tgb, r, g, b, idx;
      u = (longint'(p.pixel_x) << 16) / TILE_W;
      v = (longint'(p.pixel_y) << 16) / TILE_H;
      if (u > 'h1FFFF) u = 'h1FFFF;
      if (v > 'h1FFFF) v = 'h1FFFF;
      r = 0;
      g = 0;
      b = 0;
      for (int i = 0; i < LANES; i++) begin
         du = longint'(MID_U[i]) - u;
         dv = longint'(MID_V[i]) - v;
         twice = longint'(int_sqrt(du * du + dv * dv)) * 2;
         t = 65536 - (twice > 65536 ? 65536 : twice);
         keep = 65536 - t;
         tr = p.edge_code[i] ? 0 : 65536;
         tgb = p.edge_code[i] ? 65536 : 0;
         r = (r * keep + tr * t) >> 16;
         g = (g * keep + tgb * t) >> 16;
         b = (b * keep + tgb * t) >> 16;
      end
      o.pixel_word = {ALPHA_BYTE, 8'(gamma_byte(b)), 8'(gamma_byte(g)), 8'(gamma_byte(r))};
      idx = longint'(p.pixel_y) * longint'(stride) + longint'(p.pixel_x);
      o.pixel_index = idx[INDEX_W-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 20) begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      wts_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected response word %h index %0d", $time,
                     rsp_data.pixel_word, rsp_data.pixel_index);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_word !== want.pixel_word) begin
               $display("%0t: pixel_word expected %h actual %h", $time,
                        want.pixel_word, rsp_data.pixel_word);
               errors++;
            end
            if (rsp_data.pixel_index !== want.pixel_index) begin
               $display("%0t: pixel_index expected %0d actual %0d", $time,
                        want.pixel_index, rsp_data.pixel_index);
               errors++;
            end
         end
      end
   end

   task automatic send_pixel(input logic [6:0] x, input logic [6:0] y, input logic [3:0] code);
      wts_req_type p;
      int gap;
      p.pixel_x = x;
      p.pixel_y = y;
      p.edge_code = code;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(shade_pixel(p, cur_stride));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_stride(input logic [STRIDE_W-1:0] s);
      drain();
      csr_valid <= 1'b1;
      csr_data <= s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_stride = s;
   endtask

   task automatic test_directed();
      send_pixel(7'd0, 7'd0, 4'd0);
      send_pixel(7'd127, 7'd127, 4'd15);
      send_pixel(7'd0, 7'd127, 4'd5);
      send_pixel(7'd127, 7'd0, 4'd10);
      send_pixel(7'd127, 7'd64, 4'd1);
      send_pixel(7'd64, 7'd0, 4'd2);
      send_pixel(7'd0, 7'd64, 4'd4);
      send_pixel(7'd64, 7'd127, 4'd8);
      for (int c = 0; c < 16; c++) send_pixel(7'd64, 7'd64, 4'(c));
   endtask

   task automatic test_strides();
      logic [STRIDE_W-1:0] strides [5];
      strides = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd512};
      foreach (strides[i]) begin
         write_stride(strides[i]);
         send_pixel(7'd127, 7'd127, 4'd3);
         send_pixel(7'd5, 7'd1, 4'd12);
         send_pixel(7'd0, 7'd127, 4'd9);
      end
   endtask

   task automatic test_backpressure();
      drain();
      @(negedge clock);
      stall_left = 300;
      for (int i = 0; i < 60; i++)
         send_pixel(7'($urandom), 7'($urandom), 4'($urandom));
   endtask

   task automatic test_sender_pause();
      for (int i = 0; i < 10; i++)
         send_pixel(7'($urandom), 7'($urandom), 4'($urandom));
      drain();
      for (int i = 0; i < 10; i++)
         send_pixel(7'($urandom), 7'($urandom), 4'($urandom));
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: write_stride(13'($urandom_range(1, 4096)));
            1: write_stride(13'($urandom));
            2: write_stride(13'd8191);
            default: write_stride(13'd0);
         endcase
         req_idle_on = (ph != 3);
         rsp_idle_on = (ph != 5);
         for (int i = 0; i < 125; i++)
            send_pixel(7'($urandom), 7'($urandom), 4'($urandom));
      end
   endtask

   initial begin
      errors = 0;
      stall_left = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      cur_stride = 13'd512;
      build_gamma();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_strides();
      test_backpressure();
      test_sender_pause();
      test_random();
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/wts_pkg.sv
sv/wts_sqrt_pipe.sv
sv/wang_tile_pixel_shader_core.sv
sim/wang_tile_pixel_shader_core_tb.sv
